// File: sv/mmpq_pkg.sv
package mmpq_pkg;

    // Field widths of the transaction payloads.
    localparam int ACT_W    = 2;
    localparam int PRIO_W   = 32;
    localparam int TAG_W    = 16;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 7;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF  = 64;
    localparam int TAG_WIDTH_DEF = 16;

    // Operation codes.
    localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL_MAX = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_MIN = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Shift commands that the control logic broadcasts to every cell.
    typedef struct packed {
        logic ins;
        logic del_min;
    } t_cell_ctl;

endpackage

// File: sv/mmpq_if.sv
// Request channel: one operation per transaction.
interface mmpq_in_if
    import mmpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]         tag;

    modport source (output valid, action, priority_req, tag, input ready);
    modport sink   (input valid, action, priority_req, tag, output ready);
endinterface

// Result channel: one report per operation.
interface mmpq_out_if
    import mmpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [PRIO_W-1:0] removed_priority;
    logic [TAG_W-1:0]         removed_tag;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [PRIO_W-1:0] median_priority;
    logic [TAG_W-1:0]         median_tag;
    logic signed [PRIO_W-1:0] min_priority;
    logic [TAG_W-1:0]         min_tag;
    logic signed [PRIO_W-1:0] max_priority;
    logic [TAG_W-1:0]         max_tag;

    modport source (output valid, status, removed_priority, removed_tag, entry_count,
                    median_priority, median_tag, min_priority, min_tag,
                    max_priority, max_tag, input ready);
    modport sink   (input valid, status, removed_priority, removed_tag, entry_count,
                    median_priority, median_tag, min_priority, min_tag,
                    max_priority, max_tag, output ready);
endinterface

// File: sv/mmpq_cell.sv
// One slot of the sorted chain. Slots below the count hold entries in
// ascending order; the slot at the count position is the free slot.
module mmpq_cell
    import mmpq_pkg::*;
#(
    parameter int TAG_WIDTH = TAG_WIDTH_DEF,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [PRIO_W-1:0] i_new_prio,
    input  logic [TAG_WIDTH-1:0]     i_new_tag,
    input  logic signed [PRIO_W-1:0] i_left_prio,
    input  logic [TAG_WIDTH-1:0]     i_left_tag,
    input  logic                     i_left_gt,
    input  logic signed [PRIO_W-1:0] i_right_prio,
    input  logic [TAG_WIDTH-1:0]     i_right_tag,
    output logic signed [PRIO_W-1:0] o_prio,
    output logic [TAG_WIDTH-1:0]     o_tag,
    output logic                     o_gt
);

    logic signed [PRIO_W-1:0] r_prio;
    logic [TAG_WIDTH-1:0]     r_tag;
    logic signed [PRIO_W-1:0] n_prio;
    logic [TAG_WIDTH-1:0]     n_tag;
    logic                     w_held;

    // A free slot counts as greater than any key, so the new entry lands
    // after every held entry of equal or smaller priority.
    assign w_held = i_count > CNT_W'(INDEX);
    assign o_gt   = w_held ? (r_prio > i_new_prio) : 1'b1;

    // Insert shifts the greater part up by one; delete minimum shifts all down.
    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctl.ins && o_gt) begin
            if (i_left_gt) begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end else begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end
        end else if (i_ctl.del_min) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;

endmodule

// File: sv/mmpq_select.sv
// Picks the largest entry (slot count-1) and the median (slot (count-1)/2)
// out of the chain with a one-hot and-or selection.
module mmpq_select
    import mmpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF,
    parameter int CNT_W     = 7
) (
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [PRIO_W-1:0] i_prio [CAPACITY],
    input  logic [TAG_WIDTH-1:0]     i_tag  [CAPACITY],
    output logic signed [PRIO_W-1:0] o_max_prio,
    output logic [TAG_WIDTH-1:0]     o_max_tag,
    output logic signed [PRIO_W-1:0] o_med_prio,
    output logic [TAG_WIDTH-1:0]     o_med_tag
);

    logic [CNT_W-1:0] w_last;
    logic [CNT_W-1:0] w_mid;

    assign w_last = i_count - CNT_W'(1);
    assign w_mid  = w_last >> 1;

    always_comb begin
        o_max_prio = '0;
        o_max_tag  = '0;
        o_med_prio = '0;
        o_med_tag  = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_last == CNT_W'(k)) begin
                o_max_prio = o_max_prio | i_prio[k];
                o_max_tag  = o_max_tag  | i_tag[k];
            end
            if (w_mid == CNT_W'(k)) begin
                o_med_prio = o_med_prio | i_prio[k];
                o_med_tag  = o_med_tag  | i_tag[k];
            end
        end
    end

endmodule

// File: sv/median_min_max_priority_queue.sv
// Median min-max priority queue. Holds up to CAPACITY (priority, tag) entries
// in a chain of cells kept in ascending order, equal priorities in arrival
// order. The chain shifts in parallel at the edge that accepts an insert or
// delete-minimum transaction; delete maximum and clear change only the count.
// In the next cycle the median and the largest entry are picked out of the
// chain by a one-hot selection and registered, and the result is then shown.
// The result is held until taken, and the next request is accepted in the
// cycle after that, so no request is accepted while a result is pending.
// Deleting from an empty queue reports status 1, inserting into a full one
// reports status 2, and neither changes the contents.
module median_min_max_priority_queue
    import mmpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmpq_in_if.sink    i_in,
    mmpq_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEL  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        n_status;
    logic signed [PRIO_W-1:0] r_rem_prio;
    logic signed [PRIO_W-1:0] n_rem_prio;
    logic [TAG_WIDTH-1:0]     r_rem_tag;
    logic [TAG_WIDTH-1:0]     n_rem_tag;
    logic signed [PRIO_W-1:0] r_med_prio;
    logic [TAG_WIDTH-1:0]     r_med_tag;
    logic signed [PRIO_W-1:0] r_min_prio;
    logic [TAG_WIDTH-1:0]     r_min_tag;
    logic signed [PRIO_W-1:0] r_max_prio;
    logic [TAG_WIDTH-1:0]     r_max_tag;

    t_cell_ctl                w_ctl;
    logic                     w_accept;
    logic                     w_empty;
    logic                     w_full;
    logic [TAG_WIDTH-1:0]     w_new_tag;
    logic signed [PRIO_W-1:0] w_prio [CAPACITY];
    logic [TAG_WIDTH-1:0]     w_tag  [CAPACITY];
    logic                     w_gt   [CAPACITY];
    logic signed [PRIO_W-1:0] w_sel_max_prio;
    logic [TAG_WIDTH-1:0]     w_sel_max_tag;
    logic signed [PRIO_W-1:0] w_sel_med_prio;
    logic [TAG_WIDTH-1:0]     w_sel_med_tag;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_new_tag  = TAG_WIDTH'(i_in.tag);

    // Chain commands for the accepted operation.
    always_comb begin
        w_ctl.ins     = w_accept && (i_in.action == ACT_INSERT) && !w_full;
        w_ctl.del_min = w_accept && (i_in.action == ACT_DEL_MIN) && !w_empty;
    end

    // The chain of sorted cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == CAPACITY - 1) ? g : g + 1;

        mmpq_cell #(
            .TAG_WIDTH (TAG_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_new_prio   (i_in.priority_req),
            .i_new_tag    (w_new_tag),
            .i_left_prio  (w_prio[L]),
            .i_left_tag   (w_tag[L]),
            .i_left_gt    ((g == 0) ? 1'b0 : w_gt[L]),
            .i_right_prio (w_prio[R]),
            .i_right_tag  (w_tag[R]),
            .o_prio       (w_prio[g]),
            .o_tag        (w_tag[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Largest and median slot for the current count.
    mmpq_select #(
        .CAPACITY  (CAPACITY),
        .TAG_WIDTH (TAG_WIDTH),
        .CNT_W     (CNT_W)
    ) u_select (
        .i_count    (r_count),
        .i_prio     (w_prio),
        .i_tag      (w_tag),
        .o_max_prio (w_sel_max_prio),
        .o_max_tag  (w_sel_max_tag),
        .o_med_prio (w_sel_med_prio),
        .o_med_tag  (w_sel_med_tag)
    );

    // Count, status and removed entry of the accepted operation.
    always_comb begin
        n_count    = r_count;
        n_status   = r_status;
        n_rem_prio = r_rem_prio;
        n_rem_tag  = r_rem_tag;
        if (w_accept) begin
            n_status   = STAT_OK;
            n_rem_prio = '0;
            n_rem_tag  = '0;
            unique case (i_in.action)
                ACT_INSERT: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_DEL_MAX: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_rem_prio = w_sel_max_prio;
                        n_rem_tag  = w_sel_max_tag;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                ACT_DEL_MIN: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_rem_prio = w_prio[0];
                        n_rem_tag  = w_tag[0];
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                ACT_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Sequencer: accept, shift, select, then hold the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Result payload; the summary fields read zero on an empty queue.
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_rem_prio <= n_rem_prio;
        r_rem_tag  <= n_rem_tag;
        if (r_state == ST_SEL) begin
            if (w_empty) begin
                r_med_prio <= '0;
                r_med_tag  <= '0;
                r_min_prio <= '0;
                r_min_tag  <= '0;
                r_max_prio <= '0;
                r_max_tag  <= '0;
            end else begin
                r_med_prio <= w_sel_med_prio;
                r_med_tag  <= w_sel_med_tag;
                r_min_prio <= w_prio[0];
                r_min_tag  <= w_tag[0];
                r_max_prio <= w_sel_max_prio;
                r_max_tag  <= w_sel_max_tag;
            end
        end
    end

    assign o_out.valid            = (r_state == ST_OUT);
    assign o_out.status           = r_status;
    assign o_out.removed_priority = r_rem_prio;
    assign o_out.removed_tag      = TAG_W'(r_rem_tag);
    assign o_out.entry_count      = COUNT_W'(r_count);
    assign o_out.median_priority  = r_med_prio;
    assign o_out.median_tag       = TAG_W'(r_med_tag);
    assign o_out.min_priority     = r_min_prio;
    assign o_out.min_tag          = TAG_W'(r_min_tag);
    assign o_out.max_priority     = r_max_prio;
    assign o_out.max_tag          = TAG_W'(r_max_tag);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An insert into a queue with room grows it by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.action == ACT_INSERT) && !w_full)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    // A shown result of a non-empty queue keeps minimum at or below maximum
    // and the median between them.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !w_empty)
            |-> (r_min_prio <= r_med_prio) && (r_med_prio <= r_max_prio))
        else $error("chain order broken");

    // Requests are taken only while no result is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready && !o_out.valid)
        else $error("request taken while another is in flight");

endmodule

// File: dv/median_min_max_priority_queue_test.sv
`timescale 1ns / 1ps

module median_min_max_priority_queue_test
    import mmpq_pkg::*;
;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int RANDOM_OPS  = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};

    // One held entry, in the order the queue keeps it.
    typedef struct {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } t_held_entry;

    // Everything the block reports for one operation.
    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [PRIO_W-1:0] removed_prio;
        logic [TAG_W-1:0]         removed_tag;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [PRIO_W-1:0] median_prio;
        logic [TAG_W-1:0]         median_tag;
        logic signed [PRIO_W-1:0] min_prio;
        logic [TAG_W-1:0]         min_tag;
        logic signed [PRIO_W-1:0] max_prio;
        logic [TAG_W-1:0]         max_tag;
    } t_queue_report;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} t_stall_mode;
    typedef enum {MIX_GROW, MIX_SHRINK, MIX_STEADY, MIX_FILL, MIX_DRAIN} t_mix_kind;

    logic i_clk;
    logic i_rst_n;

    mmpq_in_if  req_if ();
    mmpq_out_if rsp_if ();

    median_min_max_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Sorted copy of the queue contents and the reports still owed by the block.
    t_held_entry   held_entries[$];
    t_queue_report pending_reports[$];

    int mismatch_count;
    int reports_checked;
    int ops_sent;
    int insert_count;
    int delete_count;
    int clear_count;
    int full_rejects;
    int empty_rejects;
    int peak_fill;
    int cycle_count;
    int burst_left;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL median_min_max_priority_queue");
            $finish;
        end
    end

    // Apply one operation to the sorted copy and build the report it produces.
    function automatic t_queue_report apply_operation(input logic [ACT_W-1:0] act,
                                                      input logic signed [PRIO_W-1:0] prio,
                                                      input logic [TAG_W-1:0] tg);
        t_queue_report rep;
        t_held_entry   ent;
        t_held_entry   gone;
        int            pos;
        int            mid;
        rep = '{default: '0};
        case (act)
            ACT_INSERT: begin
                if (held_entries.size() >= CAPACITY) begin
                    rep.status = STAT_FULL;
                    full_rejects++;
                end else begin
                    // A new entry goes after every held entry of equal priority.
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= prio)
                        pos++;
                    ent.prio = prio;
                    ent.tag  = tg;
                    held_entries.insert(pos, ent);
                    insert_count++;
                end
            end
            ACT_DEL_MAX, ACT_DEL_MIN: begin
                if (held_entries.size() == 0) begin
                    rep.status = STAT_EMPTY;
                    empty_rejects++;
                end else begin
                    gone = (act == ACT_DEL_MAX) ? held_entries.pop_back()
                                                : held_entries.pop_front();
                    rep.removed_prio = gone.prio;
                    rep.removed_tag  = gone.tag;
                    delete_count++;
                end
            end
            ACT_CLEAR: begin
                held_entries.delete();
                clear_count++;
            end
        endcase
        rep.entry_count = COUNT_W'(held_entries.size());
        if (held_entries.size() > peak_fill)
            peak_fill = held_entries.size();
        if (held_entries.size() != 0) begin
            mid = (held_entries.size() + 1) / 2 - 1;
            rep.median_prio = held_entries[mid].prio;
            rep.median_tag  = held_entries[mid].tag;
            rep.min_prio    = held_entries[0].prio;
            rep.min_tag     = held_entries[0].tag;
            rep.max_prio    = held_entries[held_entries.size()-1].prio;
            rep.max_tag     = held_entries[held_entries.size()-1].tag;
        end
        return rep;
    endfunction

    // Drive one request transaction, hold it until accepted, then pace the next.
    task automatic send_op(input logic [ACT_W-1:0] act,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tg);
        int gap;
        req_if.action       = act;
        req_if.priority_req = prio;
        req_if.tag          = tg;
        req_if.valid        = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        pending_reports.push_back(apply_operation(act, prio, tg));
        ops_sent++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            // End of a burst: an optional idle gap with junk on the payload, then a new burst length.
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req_if.valid        = 1'b0;
                req_if.action       = ACT_W'($urandom);
                req_if.priority_req = $urandom;
                req_if.tag          = TAG_W'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
        end
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
            7: begin
                case ($urandom_range(0, 3))
                    0:       return PRIO_MIN;
                    1:       return PRIO_MAX;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default:    return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input t_mix_kind kind);
        int roll;
        int insert_pct;
        roll = $urandom_range(0, 99);
        case (kind)
            MIX_GROW:   insert_pct = 80;
            MIX_SHRINK: insert_pct = 20;
            default:    insert_pct = 50;
        endcase
        if (roll == 99)
            return ACT_CLEAR;
        if (roll < insert_pct)
            return ACT_INSERT;
        return ($urandom_range(0, 1) == 0) ? ACT_DEL_MAX : ACT_DEL_MIN;
    endfunction

    // Deletes and a clear while nothing is held.
    task automatic test_empty_store();
        send_op(ACT_DEL_MAX, PRIO_MAX, 16'hFFFF);
        send_op(ACT_DEL_MIN, PRIO_MIN, 16'hFFFF);
        send_op(ACT_CLEAR, 0, 0);
    endtask

    // Entries at both ends of the priority range and the tag range.
    task automatic test_extreme_values();
        send_op(ACT_INSERT, PRIO_MAX, 16'hFFFF);
        send_op(ACT_INSERT, PRIO_MIN, 16'h0000);
        send_op(ACT_INSERT, 0, 16'hAAAA);
        send_op(ACT_INSERT, -1, 16'h5555);
        send_op(ACT_INSERT, 1, 16'h8001);
        send_op(ACT_DEL_MAX, 0, 0);
        send_op(ACT_DEL_MIN, 0, 0);
        send_op(ACT_CLEAR, PRIO_MAX, 16'hFFFF);
    endtask

    // Equal priorities are kept in arrival order: delete minimum takes the oldest, delete maximum the newest.
    task automatic test_equal_priorities();
        send_op(ACT_INSERT, 7, 16'h0001);
        send_op(ACT_INSERT, 7, 16'h0002);
        send_op(ACT_INSERT, 7, 16'h0003);
        send_op(ACT_INSERT, 7, 16'h0004);
        send_op(ACT_DEL_MAX, 0, 0);
        send_op(ACT_DEL_MIN, 0, 0);
        send_op(ACT_CLEAR, 0, 0);
    endtask

    // A lone entry is minimum, maximum and median at once.
    task automatic test_single_entry();
        send_op(ACT_INSERT, -42, 16'h1234);
        send_op(ACT_DEL_MIN, 0, 0);
        send_op(ACT_INSERT, 99, 16'hBEEF);
        send_op(ACT_DEL_MAX, 0, 0);
    endtask

    // Fill to capacity, push past it, then empty the queue and delete once more.
    task automatic test_full_store();
        send_op(ACT_CLEAR, 0, 0);
        while (held_entries.size() < CAPACITY)
            send_op(ACT_INSERT, pick_priority(), TAG_W'($urandom));
        send_op(ACT_INSERT, PRIO_MIN, 16'hFFFF);
        send_op(ACT_INSERT, PRIO_MAX, 16'h0000);
        send_op(ACT_DEL_MAX, 0, 0);
        send_op(ACT_INSERT, pick_priority(), TAG_W'($urandom));
        send_op(ACT_INSERT, pick_priority(), TAG_W'($urandom));
        while (held_entries.size() > 0)
            send_op(($urandom_range(0, 1) == 0) ? ACT_DEL_MAX : ACT_DEL_MIN, $urandom,
                    TAG_W'($urandom));
        send_op(ACT_DEL_MIN, 0, 0);
    endtask

    // Phases that grow, shrink, hold steady, fill or drain the queue with random content.
    task automatic test_random_mix(input int stop_at);
        t_mix_kind kind;
        int        len;
        while (ops_sent < stop_at) begin
            kind = t_mix_kind'($urandom_range(0, 4));
            case (kind)
                MIX_FILL: begin
                    while (held_entries.size() < CAPACITY)
                        send_op(ACT_INSERT, pick_priority(), TAG_W'($urandom));
                    repeat ($urandom_range(1, 2))
                        send_op(ACT_INSERT, pick_priority(), TAG_W'($urandom));
                end
                MIX_DRAIN: begin
                    while (held_entries.size() > 0)
                        send_op(($urandom_range(0, 1) == 0) ? ACT_DEL_MAX : ACT_DEL_MIN,
                                $urandom, TAG_W'($urandom));
                    repeat ($urandom_range(1, 2))
                        send_op(($urandom_range(0, 1) == 0) ? ACT_DEL_MAX : ACT_DEL_MIN,
                                $urandom, TAG_W'($urandom));
                end
                default: begin
                    len = $urandom_range(10, 60);
                    repeat (len)
                        send_op(pick_action(kind), pick_priority(), TAG_W'($urandom));
                end
            endcase
        end
    endtask

    // Result side stalls on its own pattern, switching modes now and then.
    initial begin : result_stall_pattern
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        logic        hold_level;
        rsp_if.ready = 1'b0;
        mode       = STALL_NONE;
        mode_left  = 0;
        hold_left  = 0;
        hold_level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 250);
            end
            mode_left--;
            case (mode)
                STALL_NONE:     rsp_if.ready = 1'b1;
                STALL_RANDOM:   rsp_if.ready = ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: rsp_if.ready = ((mode_left % 5) >= 2);
                default: begin
                    if (hold_left <= 0) begin
                        hold_level = !hold_level;
                        hold_left  = hold_level ? $urandom_range(1, 4) : $urandom_range(5, 20);
                    end
                    hold_left--;
                    rsp_if.ready = hold_level;
                end
            endcase
        end
    end

    function automatic void compare_field(input string field_name,
                                          input logic [PRIO_W-1:0] exp_val,
                                          input logic [PRIO_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %h, got %h", field_name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Compare every accepted result transaction with the oldest owed report.
    always @(posedge i_clk) begin : report_checker
        t_queue_report want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result transaction with no operation outstanding");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("status", PRIO_W'(want.status), PRIO_W'(rsp_if.status));
                compare_field("removed_priority", want.removed_prio, rsp_if.removed_priority);
                compare_field("removed_tag", PRIO_W'(want.removed_tag),
                              PRIO_W'(rsp_if.removed_tag));
                compare_field("entry_count", PRIO_W'(want.entry_count),
                              PRIO_W'(rsp_if.entry_count));
                compare_field("median_priority", want.median_prio, rsp_if.median_priority);
                compare_field("median_tag", PRIO_W'(want.median_tag), PRIO_W'(rsp_if.median_tag));
                compare_field("min_priority", want.min_prio, rsp_if.min_priority);
                compare_field("min_tag", PRIO_W'(want.min_tag), PRIO_W'(rsp_if.min_tag));
                compare_field("max_priority", want.max_prio, rsp_if.max_priority);
                compare_field("max_tag", PRIO_W'(want.max_tag), PRIO_W'(rsp_if.max_tag));
                reports_checked++;
            end
        end
    end

    // Test sequence.
    initial begin
        int directed_ops;
        mismatch_count      = 0;
        reports_checked     = 0;
        ops_sent            = 0;
        insert_count        = 0;
        delete_count        = 0;
        clear_count         = 0;
        full_rejects        = 0;
        empty_rejects       = 0;
        peak_fill           = 0;
        burst_left          = $urandom_range(1, 6);
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.action       = ACT_INSERT;
        req_if.priority_req = '0;
        req_if.tag          = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_store();
        test_extreme_values();
        test_equal_priorities();
        test_single_entry();
        directed_ops = ops_sent;
        test_full_store();
        test_random_mix(directed_ops + RANDOM_OPS);

        // Let the last reports drain, then a short quiet window.
        req_if.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d operations (%0d inserts, %0d deletes, %0d clears), %0d reports checked.",
                 ops_sent, insert_count, delete_count, clear_count, reports_checked);
        $display("Rejected %0d inserts when full and %0d deletes when empty; peak fill %0d of %0d.",
                 full_rejects, empty_rejects, peak_fill, CAPACITY);
        if (mismatch_count == 0) begin
            $display("PASS median_min_max_priority_queue");
        end else begin
            $display("FAIL median_min_max_priority_queue");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/mmpq_pkg.sv
sv/mmpq_if.sv
sv/mmpq_cell.sv
sv/mmpq_select.sv
sv/median_min_max_priority_queue.sv
dv/median_min_max_priority_queue_test.sv
